[sv/ordered_score_table_defines.svh]
// ----------------------------------------------------------------------------
// Ordered score table assertion macros
// Shared wrappers for concurrent checks clocked on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ORDERED_SCORE_TABLE_DEFINES_SVH
`define ORDERED_SCORE_TABLE_DEFINES_SVH

// same-cycle implication
`define OST_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ordered_score_table check failed");

// next-cycle implication
`define OST_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ordered_score_table check failed");

`endif

[sv/ost_pkg.sv]
// ----------------------------------------------------------------------------
// Ordered score table package
// Codes, cell control struct and the ordering compare shared by all cells.
// ----------------------------------------------------------------------------
package ost_pkg;

   // widest index and fill fields carried to the cells (capacity up to 64)
   localparam int MAX_IW = 6;
   localparam int MAX_FW = 7;

   typedef enum logic [3:0] {
      FN_ADD       = 4'd0,
      FN_INSERT    = 4'd1,
      FN_READ      = 4'd2,
      FN_FIND      = 4'd3,
      FN_EXT_POS   = 4'd4,
      FN_EXT_NAME  = 4'd5,
      FN_MOD_POS   = 4'd6,
      FN_MOD_NAME  = 4'd7,
      FN_COUNT     = 4'd8,
      FN_CLEAR     = 4'd9,
      FN_DUMP      = 4'd10
   } func_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ORD_ASC      = 2'd0,
      ORD_DESC     = 2'd1,
      ORD_NAME     = 2'd2,
      ORD_INSERT   = 2'd3
   } order_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_SORT,
      CELL_WRITE,
      CELL_INSERT,
      CELL_REMOVE,
      CELL_MODMATCH
   } cell_cmd_type;

   // broadcast to every cell each cycle
   typedef struct packed {
      cell_cmd_type       cmd;
      logic               phase;
      logic [1:0]         order;
      logic [MAX_IW-1:0]  pos;
      logic [MAX_FW-1:0]  fill;
      logic [63:0]        key;
      logic               wr_name_en;
      logic               wr_value_en;
      logic [63:0]        wr_name;
      logic signed [31:0] wr_value;
   } cell_ctl_type;

   // true when entry a must stand strictly before entry b
   function automatic logic goes_before(input logic [1:0] order,
                                        input logic [63:0] an,
                                        input logic signed [31:0] av,
                                        input logic [63:0] bn,
                                        input logic signed [31:0] bv);
      logic r;
      unique case (order)
         ORD_ASC:  r = av < bv;
         ORD_DESC: r = av > bv;
         ORD_NAME: r = an < bn;
         default:  r = 1'b0;
      endcase
      return r;
   endfunction

endpackage

[sv/ost_cell.sv]
// ----------------------------------------------------------------------------
// Ordered score table cell
// Holds one entry; shifts, swaps or rewrites it under the broadcast command.
// ----------------------------------------------------------------------------
module ost_cell #(
   parameter int CAPACITY = 16,
   parameter int IDX      = 0
) (
   input  logic                  clock,
   input  ost_pkg::cell_ctl_type ctl,
   input  logic [63:0]           left_name,
   input  logic signed [31:0]    left_value,
   input  logic [63:0]           right_name,
   input  logic signed [31:0]    right_value,
   output logic [63:0]           entry_name,
   output logic signed [31:0]    entry_value,
   output logic                  match
);
   import ost_pkg::*;

   localparam logic [MAX_IW-1:0] MY_IX = MAX_IW'(IDX);
   localparam logic [MAX_FW-1:0] MY_FX = MAX_FW'(IDX);
   localparam logic [MAX_FW-1:0] NX_FX = MAX_FW'(IDX + 1);
   localparam logic              LOW_PHASE = 1'(IDX % 2);

   logic [63:0]        name_ff, name_in;
   logic signed [31:0] value_ff, value_in;
   logic               occupied;

   assign occupied    = MY_FX < ctl.fill;
   assign match       = occupied && (name_ff == ctl.key);
   assign entry_name  = name_ff;
   assign entry_value = value_ff;

   // next entry contents
   always_comb begin
      name_in  = name_ff;
      value_in = value_ff;
      unique case (ctl.cmd)
         CELL_SORT: begin
            if (ctl.phase == LOW_PHASE) begin
               // lower cell of the pair: take right neighbor if it goes first
               if (IDX + 1 < CAPACITY && NX_FX < ctl.fill &&
                   goes_before(ctl.order, right_name, right_value, name_ff, value_ff)) begin
                  name_in  = right_name;
                  value_in = right_value;
               end
            end else begin
               if (IDX > 0 && occupied &&
                   goes_before(ctl.order, name_ff, value_ff, left_name, left_value)) begin
                  name_in  = left_name;
                  value_in = left_value;
               end
            end
         end
         CELL_WRITE: begin
            if (MY_IX == ctl.pos) begin
               if (ctl.wr_name_en)  name_in  = ctl.wr_name;
               if (ctl.wr_value_en) value_in = ctl.wr_value;
            end
         end
         CELL_INSERT: begin
            if (MY_IX > ctl.pos) begin
               name_in  = left_name;
               value_in = left_value;
            end else if (MY_IX == ctl.pos) begin
               name_in  = ctl.wr_name;
               value_in = ctl.wr_value;
            end
         end
         CELL_REMOVE: begin
            if (MY_IX >= ctl.pos) begin
               name_in  = right_name;
               value_in = right_value;
            end
         end
         CELL_MODMATCH: begin
            if (match) begin
               if (ctl.wr_name_en)  name_in  = ctl.wr_name;
               if (ctl.wr_value_en) value_in = ctl.wr_value;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      name_ff  <= name_in;
      value_ff <= value_in;
   end

endmodule

[sv/ordered_score_table.sv]
// ----------------------------------------------------------------------------
// Ordered score table
// Bounded name/value table in a row of cells, kept in the selected order.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Transfer
// req_      in         start, busy          start && !busy
// rsp_      out        rsp_strobe           every strobed cycle
// csr_      in         csr_valid, csr_ready csr_valid && csr_ready
//
// Plain items run the execute state, then return to idle.
// Successful add, insert and modify then run an odd-even transposition sort
// in the cell row when an order other than insertion is applied.
// A change to a mode other than insertion adds a sort before the item executes.
// Dump sends one result per entry, one per cycle, after the execute cycle.
// Reset clears the fill count and the applied order; the receiver cannot stall.
module ordered_score_table #(
   parameter int CAPACITY  = 16,
   parameter int KEY_BYTES = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [3:0]         req_func,
   input  logic [3:0]         req_position,
   input  logic [63:0]        req_key_name,
   input  logic [63:0]        req_new_key_name,
   input  logic signed [31:0] req_score_value,
   input  logic               req_write_name,
   input  logic               req_write_value,
   output logic               rsp_strobe,
   output logic [1:0]         rsp_status,
   output logic [63:0]        rsp_entry_name,
   output logic signed [31:0] rsp_entry_value,
   output logic [4:0]         rsp_entry_count,
   output logic               rsp_last_result,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_order_mode
);
   import ost_pkg::*;

   `include "ordered_score_table_defines.svh"

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int FW = $clog2(CAPACITY + 1);
   localparam logic [63:0] NAME_MASK = (KEY_BYTES >= 8) ? {64{1'b1}} :
                                       ((64'd1 << (8 * KEY_BYTES)) - 64'd1);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_PRE  = 5'b00010,
      S_EXEC = 5'b00100,
      S_POST = 5'b01000,
      S_DUMP = 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   logic [1:0]         mode_ff, applied_ff;
   logic [FW-1:0]      fill_ff, fill_in;
   logic [FW-1:0]      cnt_ff, cnt_in;
   logic [IW-1:0]      dump_ff, dump_in;

   // latched request
   logic [3:0]         func_ff;
   logic [3:0]         pos_ff;
   logic [63:0]        key_ff, nkey_ff;
   logic signed [31:0] val_ff;
   logic               wn_ff, wv_ff;

   // result register
   logic               strobe_ff, strobe_in;
   logic [1:0]         status_ff, status_in;
   logic [63:0]        rname_ff, rname_in;
   logic signed [31:0] rvalue_ff, rvalue_in;
   logic [4:0]         rcount_ff, rcount_in;
   logic               rlast_ff, rlast_in;

   cell_ctl_type       ctl;
   logic [63:0]        cell_name  [CAPACITY];
   logic signed [31:0] cell_value [CAPACITY];
   logic [CAPACITY-1:0] cell_match;

   logic               accept;
   logic [IW-1:0]      pos_ix, rd_ix, first_ix, last_ix;
   logic [63:0]        rd_name;
   logic signed [31:0] rd_value;
   logic               valid_pos, full, hit, sort_done;

   assign accept    = start && (state_ff == S_IDLE);
   assign busy      = state_ff != S_IDLE;
   assign csr_ready = state_ff == S_IDLE;

   assign pos_ix    = IW'(pos_ff);
   assign valid_pos = {28'd0, pos_ff} < 32'(fill_ff);
   assign full      = fill_ff == FW'(CAPACITY);
   assign hit       = |cell_match;
   assign sort_done = cnt_ff == FW'(CAPACITY - 1);

   // cell row
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      localparam int LF = (g > 0) ? g - 1 : g;
      localparam int RT = (g < CAPACITY - 1) ? g + 1 : g;
      ost_cell #(.CAPACITY(CAPACITY), .IDX(g)) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .left_name   (cell_name[LF]),
         .left_value  (cell_value[LF]),
         .right_name  (cell_name[RT]),
         .right_value (cell_value[RT]),
         .entry_name  (cell_name[g]),
         .entry_value (cell_value[g]),
         .match       (cell_match[g])
      );
   end

   // first and last matching cell
   always_comb begin
      first_ix = '0;
      last_ix  = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (cell_match[i]) first_ix = IW'(i);
      end
      for (int i = 0; i < CAPACITY; i++) begin
         if (cell_match[i]) last_ix = IW'(i);
      end
   end

   // single read port over the row
   always_comb begin
      priority case (1'b1)
         state_ff == S_DUMP:                           rd_ix = dump_ff;
         func_ff == FN_FIND || func_ff == FN_MOD_NAME: rd_ix = first_ix;
         func_ff == FN_EXT_NAME:                       rd_ix = last_ix;
         default:                                      rd_ix = pos_ix;
      endcase
   end
   assign rd_name  = cell_name[rd_ix];
   assign rd_value = cell_value[rd_ix];

   // sequencer and broadcast control
   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      cnt_in    = cnt_ff;
      dump_in   = dump_ff;
      strobe_in = 1'b0;
      status_in = ST_NOT_FOUND;
      rname_in  = '0;
      rvalue_in = -32'sd1;
      rcount_in = 5'(fill_ff);
      rlast_in  = 1'b1;

      ctl             = '0;
      ctl.cmd         = CELL_HOLD;
      ctl.phase       = cnt_ff[0];
      ctl.order       = applied_ff;
      ctl.pos         = MAX_IW'(pos_ix);
      ctl.fill        = MAX_FW'(fill_ff);
      ctl.key         = key_ff;
      ctl.wr_name_en  = wn_ff;
      ctl.wr_value_en = wv_ff;
      ctl.wr_name     = wn_ff ? nkey_ff : '0;
      ctl.wr_value    = wv_ff ? val_ff : '0;

      unique case (state_ff)
         S_IDLE: begin
            cnt_in = '0;
            if (accept) begin
               state_in = (mode_ff != applied_ff && mode_ff != ORD_INSERT)
                          ? S_PRE : S_EXEC;
            end
         end
         S_PRE: begin
            ctl.cmd = CELL_SORT;
            cnt_in  = cnt_ff + 1'b1;
            if (sort_done) state_in = S_EXEC;
         end
         S_EXEC: begin
            strobe_in = 1'b1;
            state_in  = S_IDLE;
            cnt_in    = '0;
            unique case (func_ff)
               FN_ADD: begin
                  if (full) begin
                     status_in = ST_FULL;
                  end else begin
                     ctl.cmd         = CELL_WRITE;
                     ctl.pos         = MAX_IW'(fill_ff);
                     ctl.wr_name_en  = 1'b1;
                     ctl.wr_value_en = 1'b1;
                     ctl.wr_name     = wn_ff ? key_ff : '0;
                     fill_in         = fill_ff + 1'b1;
                     status_in       = ST_OK;
                     rname_in        = ctl.wr_name;
                     rvalue_in       = ctl.wr_value;
                     state_in        = S_POST;
                  end
               end
               FN_INSERT: begin
                  if (!valid_pos) begin
                     status_in = ST_NOT_FOUND;
                  end else if (full) begin
                     status_in = ST_FULL;
                  end else begin
                     ctl.cmd     = CELL_INSERT;
                     ctl.wr_name = wn_ff ? key_ff : '0;
                     fill_in     = fill_ff + 1'b1;
                     status_in   = ST_OK;
                     rname_in    = ctl.wr_name;
                     rvalue_in   = ctl.wr_value;
                     state_in    = S_POST;
                  end
               end
               FN_READ, FN_EXT_POS: begin
                  if (valid_pos) begin
                     status_in = ST_OK;
                     rname_in  = rd_name;
                     rvalue_in = rd_value;
                     if (func_ff == FN_EXT_POS) begin
                        ctl.cmd = CELL_REMOVE;
                        fill_in = fill_ff - 1'b1;
                     end
                  end
               end
               FN_FIND: begin
                  if (hit) begin
                     status_in = ST_OK;
                     rname_in  = rd_name;
                     rvalue_in = rd_value;
                  end
               end
               FN_EXT_NAME: begin
                  if (hit) begin
                     status_in = ST_OK;
                     rname_in  = rd_name;
                     rvalue_in = rd_value;
                     ctl.cmd   = CELL_REMOVE;
                     ctl.pos   = MAX_IW'(last_ix);
                     fill_in   = fill_ff - 1'b1;
                  end
               end
               FN_MOD_POS, FN_MOD_NAME: begin
                  if ((func_ff == FN_MOD_POS) ? valid_pos : hit) begin
                     ctl.cmd   = (func_ff == FN_MOD_POS) ? CELL_WRITE : CELL_MODMATCH;
                     ctl.wr_name  = nkey_ff;
                     ctl.wr_value = val_ff;
                     status_in = ST_OK;
                     rname_in  = wn_ff ? nkey_ff : rd_name;
                     rvalue_in = wv_ff ? val_ff : rd_value;
                     state_in  = S_POST;
                  end
               end
               FN_COUNT: begin
                  status_in = ST_OK;
                  rvalue_in = '0;
               end
               FN_CLEAR: begin
                  fill_in   = '0;
                  status_in = ST_OK;
                  rvalue_in = '0;
               end
               FN_DUMP: begin
                  if (fill_ff != '0) begin
                     strobe_in = 1'b0;
                     dump_in   = '0;
                     state_in  = S_DUMP;
                  end
               end
               default: begin
               end
            endcase
            rcount_in = 5'(fill_in);
            if (state_in == S_POST && applied_ff == ORD_INSERT) state_in = S_IDLE;
         end
         S_POST: begin
            ctl.cmd = CELL_SORT;
            cnt_in  = cnt_ff + 1'b1;
            if (sort_done) state_in = S_IDLE;
         end
         S_DUMP: begin
            strobe_in = 1'b1;
            status_in = ST_OK;
            rname_in  = rd_name;
            rvalue_in = rd_value;
            rlast_in  = (FW'(dump_ff) + 1'b1) == fill_ff;
            dump_in   = dump_ff + 1'b1;
            if (rlast_in) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         mode_ff    <= ORD_INSERT;
         applied_ff <= ORD_INSERT;
         fill_ff    <= '0;
         cnt_ff     <= '0;
         dump_ff    <= '0;
         strobe_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         cnt_ff    <= cnt_in;
         dump_ff   <= dump_in;
         strobe_ff <= strobe_in;
         if (csr_valid && csr_ready) mode_ff <= csr_order_mode;
         if (accept) applied_ff <= mode_ff;
      end
   end

   // request latch and result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= req_func;
         pos_ff  <= req_position;
         key_ff  <= req_key_name & NAME_MASK;
         nkey_ff <= req_new_key_name & NAME_MASK;
         val_ff  <= req_score_value;
         wn_ff   <= req_write_name;
         wv_ff   <= req_write_value;
      end
      status_ff <= status_in;
      rname_ff  <= rname_in;
      rvalue_ff <= rvalue_in;
      rcount_ff <= rcount_in;
      rlast_ff  <= rlast_in;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_status      = status_ff;
   assign rsp_entry_name  = rname_ff;
   assign rsp_entry_value = rvalue_ff;
   assign rsp_entry_count = rcount_ff;
   assign rsp_last_result = rlast_ff;

   // checks
   `OST_ASSERT_NOW(a_fill_bound, 1'b1, fill_ff <= FW'(CAPACITY))
   `OST_ASSERT_NEXT(a_accept_busy, accept, busy)
   `OST_ASSERT_NOW(a_dump_continues, rsp_strobe && !rsp_last_result, state_ff == S_DUMP)
   `OST_ASSERT_NOW(a_idle_quiet, state_ff == S_IDLE && $past(state_ff) == S_IDLE, !rsp_strobe)

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// Ordered score table testbench
// Drives table operations through the start/busy port, predicts each result
// with a behavioral copy of the table and compares every strobed result in
// order. The order mode is rewritten between phases while the table is idle.
// ----------------------------------------------------------------------------
module testbench;
   import ost_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAP = 16;

   typedef struct {
      logic [3:0]         func;
      logic [3:0]         position;
      logic [63:0]        key_name;
      logic [63:0]        new_key_name;
      logic signed [31:0] score_value;
      logic               write_name;
      logic               write_value;
   } op_item_type;

   typedef struct {
      logic [1:0]         status;
      logic [63:0]        entry_name;
      logic signed [31:0] entry_value;
      logic [4:0]         entry_count;
      logic               last_result;
   } entry_rsp_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [3:0]         req_func;
   logic [3:0]         req_position;
   logic [63:0]        req_key_name;
   logic [63:0]        req_new_key_name;
   logic signed [31:0] req_score_value;
   logic               req_write_name;
   logic               req_write_value;
   logic               rsp_strobe;
   logic [1:0]         rsp_status;
   logic [63:0]        rsp_entry_name;
   logic signed [31:0] rsp_entry_value;
   logic [4:0]         rsp_entry_count;
   logic               rsp_last_result;
   logic               csr_valid;
   logic               csr_ready;
   logic [1:0]         csr_order_mode;

   // model state
   logic [63:0]        tbl_name [CAP];
   logic signed [31:0] tbl_value[CAP];
   int                 tbl_fill;
   logic [1:0]         tbl_order;
   logic [1:0]         mode_reg;

   op_item_type   pending_ops[$];
   entry_rsp_type expected_rsps[$];
   int            error_count;
   int            gap_left;

   ordered_score_table uut (.*);

   // clock
   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] exp);
      $display("mismatch %s: got %h expected %h at %0t", what, got, exp, $realtime);
      error_count++;
   endtask

   function automatic logic ranks_ahead(input logic [63:0] an, input logic signed [31:0] av,
                                        input logic [63:0] bn, input logic signed [31:0] bv);
      case (order_type'(tbl_order))
         ORD_ASC:  return av < bv;
         ORD_DESC: return av > bv;
         ORD_NAME: return an < bn;
         default:  return 1'b0;
      endcase
   endfunction

   // stable insertion sort in the applied order
   task automatic sort_entries();
      logic [63:0]        n;
      logic signed [31:0] v;
      int                 j;
      for (int i = 1; i < tbl_fill; i++) begin
         n = tbl_name[i];
         v = tbl_value[i];
         j = i;
         while (j > 0 && ranks_ahead(n, v, tbl_name[j-1], tbl_value[j-1])) begin
            tbl_name[j]  = tbl_name[j-1];
            tbl_value[j] = tbl_value[j-1];
            j--;
         end
         tbl_name[j]  = n;
         tbl_value[j] = v;
      end
   endtask

   task automatic drop_entry(input int p);
      for (int i = p; i + 1 < tbl_fill; i++) begin
         tbl_name[i]  = tbl_name[i+1];
         tbl_value[i] = tbl_value[i+1];
      end
      tbl_fill--;
   endtask

   task automatic push_rsp(input logic [1:0] st, input logic [63:0] n,
                           input logic signed [31:0] v, input logic last);
      entry_rsp_type r;
      r.status      = st;
      r.entry_name  = n;
      r.entry_value = v;
      r.entry_count = 5'(tbl_fill);
      r.last_result = last;
      expected_rsps.push_back(r);
   endtask

   // apply one operation to the table model and queue its results
   task automatic predict_table_op(input op_item_type op);
      logic [63:0]        rn;
      logic signed [31:0] rv;
      logic [1:0]         st;
      logic               hit;
      logic               pos_ok;
      int                 p;
      int                 found;
      rn = '0;
      rv = -1;
      st = ST_NOT_FOUND;
      hit = 1'b0;
      found = 0;
      p = int'(op.position);
      if (tbl_order != mode_reg) begin
         tbl_order = mode_reg;
         sort_entries();
      end
      pos_ok = p < tbl_fill;
      case (op.func)
         FN_ADD: begin
            if (tbl_fill >= CAP) st = ST_FULL;
            else begin
               rn = op.write_name ? op.key_name : '0;
               rv = op.write_value ? op.score_value : '0;
               tbl_name[tbl_fill]  = rn;
               tbl_value[tbl_fill] = rv;
               tbl_fill++;
               sort_entries();
               st = ST_OK;
            end
         end
         FN_INSERT: begin
            if (pos_ok && tbl_fill >= CAP) st = ST_FULL;
            else if (pos_ok) begin
               for (int i = tbl_fill; i > p; i--) begin
                  tbl_name[i]  = tbl_name[i-1];
                  tbl_value[i] = tbl_value[i-1];
               end
               rn = op.write_name ? op.key_name : '0;
               rv = op.write_value ? op.score_value : '0;
               tbl_name[p]  = rn;
               tbl_value[p] = rv;
               tbl_fill++;
               sort_entries();
               st = ST_OK;
            end
         end
         FN_READ, FN_EXT_POS: begin
            if (pos_ok) begin
               rn = tbl_name[p];
               rv = tbl_value[p];
               if (op.func == FN_EXT_POS) drop_entry(p);
               st = ST_OK;
            end
         end
         FN_FIND: begin
            for (int i = 0; i < tbl_fill; i++)
               if (!hit && tbl_name[i] == op.key_name) begin
                  rn = tbl_name[i];
                  rv = tbl_value[i];
                  st = ST_OK;
                  hit = 1'b1;
               end
         end
         FN_EXT_NAME: begin
            for (int i = 0; i < tbl_fill; i++)
               if (tbl_name[i] == op.key_name) begin
                  found = i;
                  hit = 1'b1;
               end
            if (hit) begin
               rn = tbl_name[found];
               rv = tbl_value[found];
               drop_entry(found);
               st = ST_OK;
            end
         end
         FN_MOD_POS: begin
            if (pos_ok) begin
               if (op.write_name) tbl_name[p] = op.new_key_name;
               if (op.write_value) tbl_value[p] = op.score_value;
               rn = tbl_name[p];
               rv = tbl_value[p];
               sort_entries();
               st = ST_OK;
            end
         end
         FN_MOD_NAME: begin
            for (int i = 0; i < tbl_fill; i++)
               if (tbl_name[i] == op.key_name) begin
                  if (op.write_name) tbl_name[i] = op.new_key_name;
                  if (op.write_value) tbl_value[i] = op.score_value;
                  if (!hit) begin
                     rn = tbl_name[i];
                     rv = tbl_value[i];
                     hit = 1'b1;
                  end
               end
            if (hit) begin
               sort_entries();
               st = ST_OK;
            end
         end
         FN_COUNT: begin
            rn = '0;
            rv = '0;
            st = ST_OK;
         end
         FN_CLEAR: begin
            tbl_fill = 0;
            rn = '0;
            rv = '0;
            st = ST_OK;
         end
         FN_DUMP: begin
            if (tbl_fill > 0) begin
               for (int i = 0; i < tbl_fill; i++)
                  push_rsp(ST_OK, tbl_name[i], tbl_value[i], i + 1 == tbl_fill);
               return;
            end
         end
         default: ;
      endcase
      push_rsp(st, rn, rv, 1'b1);
   endtask

   // driver: one item per start transfer, random gap before each
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_left <= 0;
      end else if (start && !busy) begin
         // transfer happened at the last rising edge
      end else if (!start && pending_ops.size() > 0) begin
         if (gap_left > 0) gap_left <= gap_left - 1;
         else begin
            op_item_type op;
            op = pending_ops.pop_front();
            req_func         <= op.func;
            req_position     <= op.position;
            req_key_name     <= op.key_name;
            req_new_key_name <= op.new_key_name;
            req_score_value  <= op.score_value;
            req_write_name   <= op.write_name;
            req_write_value  <= op.write_value;
            start            <= 1'b1;
            gap_left         <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
         end
      end
   end

   // lower start after its transfer; no second assignment in the same step
   always @(posedge clock) begin
      op_item_type op;
      if (!reset && start && !busy) begin
         op.func         = req_func;
         op.position     = req_position;
         op.key_name     = req_key_name;
         op.new_key_name = req_new_key_name;
         op.score_value  = req_score_value;
         op.write_name   = req_write_name;
         op.write_value  = req_write_value;
         predict_table_op(op);
         start <= 1'b0;
      end
   end

   // monitor
   always @(posedge clock) begin
      entry_rsp_type e;
      if (!reset && rsp_strobe) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected result", 64'(rsp_status), '0);
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_status !== e.status)
               report_mismatch("status", 64'(rsp_status), 64'(e.status));
            if (rsp_entry_name !== e.entry_name)
               report_mismatch("entry_name", rsp_entry_name, e.entry_name);
            if (rsp_entry_value !== e.entry_value)
               report_mismatch("entry_value", 64'(rsp_entry_value), 64'(e.entry_value));
            if (rsp_entry_count !== e.entry_count)
               report_mismatch("entry_count", 64'(rsp_entry_count), 64'(e.entry_count));
            if (rsp_last_result !== e.last_result)
               report_mismatch("last_result", 64'(rsp_last_result), 64'(e.last_result));
         end
      end
   end

   function automatic op_item_type make_op(input func_type f, input int p,
                                           input logic [63:0] k,
                                           input logic signed [31:0] v,
                                           input logic wn, input logic wv);
      op_item_type op;
      op.func         = f;
      op.position     = 4'(p);
      op.key_name     = k;
      op.new_key_name = {$urandom, $urandom};
      op.score_value  = v;
      op.write_name   = wn;
      op.write_value  = wv;
      return op;
   endfunction

   // names from a small pool so that lookups hit often
   function automatic logic [63:0] pick_name();
      case ($urandom_range(0, 5))
         0: return 64'h0;
         1: return 64'hFFFF_FFFF_FFFF_FFFF;
         2, 3: return 64'($urandom_range(1, 6)) << 56;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 4))
         0: return 32'sh8000_0000;
         1: return 32'sh7FFF_FFFF;
         2: return $urandom_range(0, 4);
         default: return $urandom;
      endcase
   endfunction

   function automatic op_item_type random_op();
      op_item_type op;
      int f;
      f = $urandom_range(0, 24);
      if (f > 15) f = $urandom_range(0, 1) ? int'(FN_ADD) : $urandom_range(0, 7);
      if (f > 10 && $urandom_range(0, 2) != 0) f = $urandom_range(0, 10);
      op.func         = 4'(f);
      op.position     = $urandom_range(0, 3) == 0 ? 4'($urandom) : 4'($urandom_range(0, 5));
      op.key_name     = pick_name();
      op.new_key_name = pick_name();
      op.score_value  = pick_value();
      op.write_name   = $urandom_range(0, 4) != 0;
      op.write_value  = $urandom_range(0, 4) != 0;
      return op;
   endfunction

   task automatic write_order(input logic [1:0] m);
      @(negedge clock);
      csr_order_mode <= m;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      mode_reg = m;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain_table();
      while (pending_ops.size() > 0 || start || expected_rsps.size() > 0) @(posedge clock);
      repeat (3 * CAP + 8) @(posedge clock);
   endtask

   // stimulus
   initial begin
      logic [1:0] modes[6];
      error_count = 0;
      tbl_fill = 0;
      tbl_order = ORD_INSERT;
      mode_reg = ORD_INSERT;
      reset = 1'b1;
      start = 1'b0;
      req_func = '0;
      req_position = '0;
      req_key_name = '0;
      req_new_key_name = '0;
      req_score_value = '0;
      req_write_name = 1'b0;
      req_write_value = 1'b0;
      csr_valid = 1'b0;
      csr_order_mode = ORD_INSERT;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty table errors, extremes, every operation
      pending_ops.push_back(make_op(FN_DUMP, 0, 0, 0, 0, 0));
      pending_ops.push_back(make_op(FN_INSERT, 0, 1, 1, 1, 1));
      pending_ops.push_back(make_op(FN_READ, 0, 0, 0, 0, 0));
      pending_ops.push_back(make_op(FN_ADD, 0, 64'hFFFF_FFFF_FFFF_FFFF, 32'sh7FFF_FFFF, 1, 1));
      pending_ops.push_back(make_op(FN_ADD, 0, 64'h4200_0000_0000_0000, 32'sh8000_0000, 1, 1));
      pending_ops.push_back(make_op(FN_ADD, 0, 64'h1234, 5, 0, 0));
      pending_ops.push_back(make_op(FN_INSERT, 1, 64'h4200_0000_0000_0000, 7, 1, 1));
      pending_ops.push_back(make_op(FN_FIND, 0, 64'h4200_0000_0000_0000, 0, 0, 0));
      pending_ops.push_back(make_op(FN_FIND, 0, 64'h99, 0, 0, 0));
      pending_ops.push_back(make_op(FN_MOD_POS, 2, 0, -3, 0, 0));
      pending_ops.push_back(make_op(FN_MOD_POS, 2, 0, -3, 1, 1));
      pending_ops.push_back(make_op(FN_MOD_NAME, 0, 64'h4200_0000_0000_0000, 9, 0, 1));
      pending_ops.push_back(make_op(FN_EXT_NAME, 0, 64'h4200_0000_0000_0000, 0, 0, 0));
      pending_ops.push_back(make_op(FN_EXT_POS, 15, 0, 0, 0, 0));
      pending_ops.push_back(make_op(FN_EXT_POS, 0, 0, 0, 0, 0));
      pending_ops.push_back(make_op(FN_COUNT, 0, 0, 0, 0, 0));
      pending_ops.push_back(make_op(FN_DUMP, 0, 0, 0, 0, 0));
      pending_ops.push_back(make_op(func_type'(4'd15), 0, 0, 0, 0, 0));
      pending_ops.push_back(make_op(func_type'(4'd11), 0, 0, 0, 0, 0));
      for (int i = 0; i < 17; i++)
         pending_ops.push_back(make_op(FN_ADD, 0, pick_name(), pick_value(), 1, 1));
      pending_ops.push_back(make_op(FN_INSERT, 3, 1, 1, 1, 1));
      pending_ops.push_back(make_op(FN_DUMP, 0, 0, 0, 0, 0));
      pending_ops.push_back(make_op(FN_CLEAR, 0, 0, 0, 0, 0));
      drain_table();

      // random phases across every order mode, extremes included
      modes = '{ORD_ASC, ORD_DESC, ORD_NAME, ORD_INSERT, ORD_DESC, ORD_ASC};
      foreach (modes[m]) begin
         write_order(modes[m]);
         for (int i = 0; i < 30; i++) pending_ops.push_back(random_op());
         pending_ops.push_back(make_op(FN_DUMP, 0, 0, 0, 0, 0));
         // the mode goes to ascending and back to name order while idle; the applied order is unchanged, so no re-sort
         if (m == 2) begin
            drain_table();
            write_order(ORD_ASC);
            mode_reg = ORD_ASC;
            write_order(ORD_NAME);
            for (int i = 0; i < 5; i++) pending_ops.push_back(random_op());
         end
         drain_table();
      end
      drain_table();
      if (error_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

   // overall limit
   initial begin
      #2ms;
      $display("Regression FAIL");
      $finish;
   end
endmodule
